### rtl/dqe_pkg.sv
// dqe_pkg: shared types and constants for the dns question extractor
// no dependencies; used by the core and the top level

package dqe_pkg;

  localparam int POS_W = 11;
  localparam int CNT_W = 8;
  localparam int TRL_W = 3;
  localparam int LIM_W = 7;

  localparam logic [POS_W-1:0] UDPLEN_POS   = POS_W'(38);
  localparam logic [POS_W-1:0] QUESTION_POS = POS_W'(54);
  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
  localparam logic [TRL_W-1:0] TRAILER_BYTES = TRL_W'(4);
  localparam int               DNS_HDR       = 12;
  localparam logic [LIM_W-1:0] NAME_LIMIT_RST = LIM_W'(125);

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_LABEL   = 5'b00100,
    PH_TRAILER = 5'b01000,
    PH_DONE    = 5'b10000
  } dqe_phase_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
    logic       frame_end;
  } dqe_in_t;

  typedef struct packed {
    logic             has_result;
    logic [7:0]       question_byte;
    logic [CNT_W-1:0] byte_index;
    logic             byte_valid;
    logic             last_byte;
    logic             cut_short;
  } dqe_result_t;

endpackage

### rtl/dqe_in_if.sv
// dqe_in_if: frame byte stream channel, valid/ready handshake
// no dependencies

interface dqe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_start, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_start, frame_end, output ready);
endinterface

### rtl/dqe_out_if.sv
// dqe_out_if: question byte result channel, valid/ready handshake
// no dependencies

interface dqe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] question_byte;
  logic [7:0] byte_index;
  logic       byte_valid;
  logic       last_byte;
  logic       cut_short;

  modport source (output valid, question_byte, byte_index, byte_valid, last_byte,
                  cut_short, input ready);
  modport sink (input valid, question_byte, byte_index, byte_valid, last_byte,
                cut_short, output ready);
endinterface

### rtl/dqe_parse_core.sv
// dqe_parse_core: per-frame parse state and combinational step logic
// depends on dqe_pkg

module dqe_parse_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step_en,
  input  dqe_pkg::dqe_in_t                   step_in,
  input  logic [dqe_pkg::LIM_W-1:0]          name_limit,
  output dqe_pkg::dqe_result_t               step_res
);
  import dqe_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      udp_r, udp_nxt;
  dqe_phase_t       phase_r, phase_nxt;
  logic [CNT_W-1:0] lab_r, lab_nxt;
  logic [CNT_W-1:0] cc_r, cc_nxt;
  logic [TRL_W-1:0] tc_r, tc_nxt;

  logic [POS_W-1:0] eff_pos;
  logic [15:0]      eff_udp;
  dqe_phase_t       eff_phase, phase0;
  logic [CNT_W-1:0] eff_lab, eff_cc, cc_inc, lab_dec;
  logic [TRL_W-1:0] eff_tc, tc_inc;
  logic signed [17:0] len_room;
  logic             cc_reach, over_limit;
  logic             valid, last, cut;

  assign eff_pos   = step_in.frame_start ? '0 : pos_r;
  assign eff_udp   = step_in.frame_start ? '0 : udp_r;
  assign eff_phase = step_in.frame_start ? PH_HEADER : phase_r;
  assign eff_lab   = step_in.frame_start ? '0 : lab_r;
  assign eff_cc    = step_in.frame_start ? '0 : cc_r;
  assign eff_tc    = step_in.frame_start ? '0 : tc_r;

  assign phase0 = (eff_phase == PH_HEADER && eff_pos >= QUESTION_POS) ? PH_LEN : eff_phase;
  assign cc_inc  = eff_cc + CNT_W'(1);
  assign lab_dec = eff_lab - CNT_W'(1);
  assign tc_inc  = eff_tc + TRL_W'(1);

  // signed compare of copied count against udp length minus dns header
  assign len_room   = $signed({2'b00, eff_udp}) - 18'sd12;
  assign cc_reach   = $signed({{(18-CNT_W){1'b0}}, cc_inc}) >= len_room;
  assign over_limit = cc_inc > {{(CNT_W-LIM_W){1'b0}}, name_limit};

  always_comb begin
    pos_nxt   = (eff_pos < POS_MAX) ? eff_pos + POS_W'(1) : eff_pos;
    udp_nxt   = eff_udp;
    phase_nxt = phase0;
    lab_nxt   = eff_lab;
    cc_nxt    = eff_cc;
    tc_nxt    = eff_tc;
    valid     = 1'b0;
    last      = 1'b0;
    cut       = 1'b0;
    step_res  = '0;

    case (phase0)
      PH_HEADER: begin
        if (eff_pos == UDPLEN_POS) begin
          udp_nxt[15:8] = step_in.frame_byte;
        end else if (eff_pos == UDPLEN_POS + POS_W'(1)) begin
          udp_nxt[7:0] = step_in.frame_byte;
        end
      end
      PH_LEN: begin
        valid  = 1'b1;
        cc_nxt = cc_inc;
        if (step_in.frame_byte == 8'd0 || cc_reach) begin
          phase_nxt = PH_TRAILER;
        end else begin
          lab_nxt   = step_in.frame_byte;
          phase_nxt = over_limit ? PH_TRAILER : PH_LABEL;
        end
      end
      PH_LABEL: begin
        valid   = 1'b1;
        cc_nxt  = cc_inc;
        lab_nxt = lab_dec;
        if (lab_dec == '0) begin
          phase_nxt = PH_LEN;
        end else if (over_limit) begin
          phase_nxt = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        valid  = 1'b1;
        cc_nxt = cc_inc;
        tc_nxt = tc_inc;
        if (tc_inc >= TRAILER_BYTES) begin
          phase_nxt = PH_DONE;
          last      = 1'b1;
        end
      end
      default: begin
      end
    endcase

    step_res.question_byte = step_in.frame_byte;
    step_res.byte_index    = eff_cc;
    step_res.byte_valid    = valid;
    step_res.has_result    = valid;

    // frame ended before the question closed
    if (step_in.frame_end) begin
      if (valid) begin
        if (!last) begin
          last      = 1'b1;
          cut       = 1'b1;
          phase_nxt = PH_DONE;
        end
      end else if (phase_nxt != PH_DONE) begin
        last                   = 1'b1;
        cut                    = 1'b1;
        phase_nxt              = PH_DONE;
        step_res.has_result    = 1'b1;
        step_res.question_byte = 8'd0;
      end
    end

    step_res.last_byte = last;
    step_res.cut_short = cut;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      udp_r   <= '0;
      phase_r <= PH_HEADER;
      lab_r   <= '0;
      cc_r    <= '0;
      tc_r    <= '0;
    end else if (step_en) begin
      pos_r   <= pos_nxt;
      udp_r   <= udp_nxt;
      phase_r <= phase_nxt;
      lab_r   <= lab_nxt;
      cc_r    <= cc_nxt;
      tc_r    <= tc_nxt;
    end
  end

  a_last_goes_done: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && step_res.has_result && step_res.last_byte |=> phase_r == PH_DONE)
    else $error("question closed but parser not done");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE && !step_in.frame_start |-> !step_res.has_result)
    else $error("result after question closed");

  a_label_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LABEL |-> lab_r != '0)
    else $error("label phase with nothing left");

endmodule

### rtl/dns_question_extractor.sv
// Takes an Ethernet frame one byte per transaction and returns the DNS question bytes
// (labels, then qtype and qclass) found from frame byte 54 on, assuming a 20-byte IPv4
// header. A byte is accepted every cycle while the result register is empty or being
// taken; its result, if any, appears in the cycle after. Throughput is one byte per cycle,
// limited only by the single result register. name_limit resets to 125.
// depends on dqe_pkg, dqe_in_if, dqe_out_if, dqe_parse_core

module dns_question_extractor (
  input  logic                      clk,
  input  logic                      rst_n,
  dqe_in_if.sink                    in_ch,
  dqe_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [dqe_pkg::LIM_W-1:0] cfg_wdata
);
  import dqe_pkg::*;

  logic [LIM_W-1:0] name_limit_r;
  logic             out_valid_r;
  dqe_result_t      res_r;
  dqe_result_t      step_res;
  dqe_in_t          step_in;
  logic             in_accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign step_in.frame_byte  = in_ch.frame_byte;
  assign step_in.frame_start = in_ch.frame_start;
  assign step_in.frame_end   = in_ch.frame_end;

  dqe_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .step_in    (step_in),
    .name_limit (name_limit_r),
    .step_res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r <= NAME_LIMIT_RST;
    end else if (cfg_we) begin
      name_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= step_res.has_result;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.question_byte = res_r.question_byte;
  assign out_ch.byte_index    = res_r.byte_index;
  assign out_ch.byte_valid    = res_r.byte_valid;
  assign out_ch.last_byte     = res_r.last_byte;
  assign out_ch.cut_short     = res_r.cut_short;

  a_cut_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.cut_short |-> res_r.last_byte)
    else $error("cut_short without last_byte");

  a_empty_is_cut: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.byte_valid |-> res_r.cut_short && res_r.question_byte == 8'd0)
    else $error("empty result that is not a cut");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule
